>>> hdl/msk_pkg.sv
// Package with the shared types and codes of the min-tracking stack.
`timescale 1ns / 1ps
`default_nettype none

package msk_pkg;

  localparam int STACK_DEPTH_DEFAULT = 64;

  localparam int VALUE_W = 32;
  localparam int COUNT_OUT_W = 7;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // One stack entry: the pushed value and the minimum of the stack at that push.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [VALUE_W-1:0] minimum;
  } entry_t;

  // Shift controls that all cells share.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

`default_nettype wire

>>> hdl/msk_cell.sv
// One cell of the shifting stack: holds one entry and moves it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module msk_cell (
  input  wire logic               clk,
  input  wire msk_pkg::shift_ctl_t ctl,
  input  wire msk_pkg::entry_t    from_above,
  input  wire msk_pkg::entry_t    from_below,
  output msk_pkg::entry_t         entry
);

  msk_pkg::entry_t entry_r;
  msk_pkg::entry_t entry_nxt;

  // A push moves every entry one cell deeper; a pop moves every entry one cell up.
  always_comb begin
    entry_nxt = entry_r;
    unique if (ctl.push) begin
      entry_nxt = from_above;
    end else if (ctl.pop) begin
      entry_nxt = from_below;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

>>> hdl/min_tracking_stack.sv
// Top level of the min-tracking stack: a row of shifting cells plus the depth counter.
`timescale 1ns / 1ps
`default_nettype none

// The block is a last-in first-out stack of signed 32-bit values that also
// tracks the smallest value held. A transaction is accepted on a rising edge
// with start high and busy low; busy is always low, because every operation
// finishes at once, as the whole row of STACK_DEPTH cells shifts all entries
// one place down (push) or up (pop) together. The result shows in
// the cycle right after acceptance, marked by out_valid for exactly that one
// cycle, and the receiver cannot hold it off, so it must take every result as
// it comes. A new transaction may be accepted in the same cycle in which the
// previous result is shown, giving one operation per clock cycle sustained.
// Each cell keeps its value together with the minimum of the stack at the time
// it was pushed, so the top cell always holds the current minimum. A push onto
// a full stack is rejected with status full, a pop on an empty stack is
// ignored with status empty, and an unused opcode acts as a read. While the
// stack is empty, the top and minimum outputs read as zero. The stack memory
// needs no clearing after reset: only entries below the depth count are shown.
module min_tracking_stack #(
  parameter int STACK_DEPTH = msk_pkg::STACK_DEPTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_opcode,
  input  wire logic signed [msk_pkg::VALUE_W-1:0] in_push_value,
  output logic                                  out_valid,
  output logic signed [msk_pkg::VALUE_W-1:0]    out_top_value,
  output logic signed [msk_pkg::VALUE_W-1:0]    out_min_value,
  output logic [msk_pkg::COUNT_OUT_W-1:0]       out_entry_count,
  output logic                                  out_is_empty,
  output logic [1:0]                            out_status
);

  // The counter must hold STACK_DEPTH itself and at least the reported width.
  localparam int DEPTH_CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W = (DEPTH_CNT_W > msk_pkg::COUNT_OUT_W) ?
                         DEPTH_CNT_W : msk_pkg::COUNT_OUT_W;

  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic                valid_r;
  logic [1:0]          status_r;
  logic [1:0]          status_nxt;

  logic                accept;
  logic                stack_full;
  logic                stack_empty;
  logic                op_push;
  logic                op_pop;
  msk_pkg::shift_ctl_t ctl;
  msk_pkg::entry_t     new_entry;
  msk_pkg::entry_t     cells [STACK_DEPTH];

  // No operation ever waits, so the block never holds off start.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign stack_full  = (cnt_r == CNT_W'(STACK_DEPTH));
  assign stack_empty = (cnt_r == '0);
  assign op_push     = (in_opcode == msk_pkg::OP_PUSH);
  assign op_pop      = (in_opcode == msk_pkg::OP_POP);

  // Shifts happen only for operations that actually change the stack.
  assign ctl.push = accept && op_push && !stack_full;
  assign ctl.pop  = accept && op_pop && !stack_empty;

  // The new entry's minimum is the smaller of its value and the current minimum;
  // on an empty stack the value is its own minimum.
  always_comb begin
    new_entry.value = in_push_value;
    if (stack_empty || ($signed(in_push_value) <= $signed(cells[0].minimum))) begin
      new_entry.minimum = in_push_value;
    end else begin
      new_entry.minimum = cells[0].minimum;
    end
  end

  // Cell 0 is the top of the stack. On a pop the deepest cell keeps its own
  // contents, which lie beyond the count and are never shown.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    msk_pkg::entry_t above;
    msk_pkg::entry_t below;

    if (i == 0) begin : g_top
      assign above = new_entry;
    end else begin : g_mid_top
      assign above = cells[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign below = cells[i];
    end else begin : g_mid_bottom
      assign below = cells[i+1];
    end

    msk_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_above (above),
      .from_below (below),
      .entry      (cells[i])
    );
  end

  always_comb begin
    cnt_nxt = cnt_r;
    unique if (ctl.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_comb begin
    priority if (op_push && stack_full) begin
      status_nxt = msk_pkg::ST_FULL;
    end else if (op_pop && stack_empty) begin
      status_nxt = msk_pkg::ST_EMPTY;
    end else begin
      status_nxt = msk_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  // The result reads straight from the top cell and the counter, which the
  // accepted operation updated at the edge that starts the result cycle.
  assign out_valid       = valid_r;
  assign out_is_empty    = (cnt_r == '0);
  assign out_top_value   = out_is_empty ? '0 : $signed(cells[0].value);
  assign out_min_value   = out_is_empty ? '0 : $signed(cells[0].minimum);
  assign out_entry_count = cnt_r[msk_pkg::COUNT_OUT_W-1:0];
  assign out_status      = status_r;

endmodule

`default_nettype wire

>>> hdl/msk_checker.sv
// Port-level checker of the min-tracking stack and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module msk_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            out_valid,
  input wire logic [msk_pkg::VALUE_W-1:0]     out_top_value,
  input wire logic [msk_pkg::VALUE_W-1:0]     out_min_value,
  input wire logic [msk_pkg::COUNT_OUT_W-1:0] out_entry_count,
  input wire logic                            out_is_empty,
  input wire logic [1:0]                      out_status
);

  // Exactly one result follows each accepted transaction, in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted transaction gave no result");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without an accepted transaction");

  // An empty stack reports zero count and zero top and minimum.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |->
      (out_entry_count == '0 && out_top_value == '0 && out_min_value == '0))
    else $error("empty stack shows data");

  // The tracked minimum never exceeds the top value.
  a_min_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_empty) |-> ($signed(out_min_value) <= $signed(out_top_value)))
    else $error("minimum above top value");

  // A rejected push happens only on a stack that holds entries.
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == msk_pkg::ST_FULL) |-> !out_is_empty)
    else $error("full status on an empty stack");

endmodule

bind min_tracking_stack msk_checker u_msk_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_top_value   (out_top_value),
  .out_min_value   (out_min_value),
  .out_entry_count (out_entry_count),
  .out_is_empty    (out_is_empty),
  .out_status      (out_status)
);

`default_nettype wire
